// File: hw/rtl/mrws_pkg.sv
// mrws_pkg: item structs, reservoir record, shared unit op codes and widths
// for the multi-reservoir weighted sampler; no dependencies
package mrws_pkg;

    localparam int NUM_RESERVOIRS_DEF = 4;

    localparam int SLOT_W  = 6;
    localparam int POS_W   = 32;
    localparam int COLOR_W = 16;
    localparam int WEIGHT_W = 32;
    localparam int DRAW_W  = 16;
    localparam int SUM_W   = 32;
    localparam int CNT_W   = 32;
    localparam int TOTAL_W = 38;
    localparam int PROD_W  = DRAW_W + SUM_W;

    // shared unit op codes
    localparam logic [1:0] OP_LESS   = 2'd0;
    localparam logic [1:0] OP_ADDSAT = 2'd1;
    localparam logic [1:0] OP_MUL    = 2'd2;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic [COLOR_W-1:0]      color_r;
        logic [COLOR_W-1:0]      color_g;
        logic [COLOR_W-1:0]      color_b;
        logic [WEIGHT_W-1:0]     cand_weight;
        logic [DRAW_W-1:0]       uniform_draw;
    } in_item_t;

    typedef struct packed {
        logic [SLOT_W-1:0]  chosen_slot;
        logic               replaced;
        logic [SUM_W-1:0]   slot_sum;
        logic [TOTAL_W-1:0] total_count;
    } out_item_t;

    // one reservoir as kept in the store
    typedef struct packed {
        logic [SUM_W-1:0]        sum;
        logic [CNT_W-1:0]        cnt;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic [COLOR_W-1:0]      color_r;
        logic [COLOR_W-1:0]      color_g;
        logic [COLOR_W-1:0]      color_b;
    } rec_t;

    typedef struct packed {
        logic [1:0]        op;
        logic [PROD_W-1:0] a;
        logic [PROD_W-1:0] b;
    } unit_req_t;

endpackage

// File: hw/rtl/mrws_unit.sv
// mrws_unit: shared arithmetic unit (compare, saturating add, multiply)
// depends on mrws_pkg
module mrws_unit
    import mrws_pkg::*;
(
    input  unit_req_t         req,
    output logic [PROD_W-1:0] res
);

    logic [SUM_W:0] add_full;

    always_comb begin
        add_full = {1'b0, req.a[SUM_W-1:0]} + {1'b0, req.b[SUM_W-1:0]};
        case (req.op)
            OP_LESS: begin
                res = PROD_W'(req.a < req.b);
            end
            OP_ADDSAT: begin
                // clamp to all ones on carry out
                res = PROD_W'(add_full[SUM_W] ? {SUM_W{1'b1}} : add_full[SUM_W-1:0]);
            end
            OP_MUL: begin
                res = PROD_W'(req.a[DRAW_W-1:0]) * PROD_W'(req.b[SUM_W-1:0]);
            end
            default: begin
                res = '0;
            end
        endcase
    end

endmodule

// File: hw/rtl/mrws_store.sv
// mrws_store: reservoir record memory, one write and one registered read port,
// valid bit per entry so unwritten entries read as zero; depends on mrws_pkg
module mrws_store
    import mrws_pkg::*;
#(
    parameter int NUM_RESERVOIRS = NUM_RESERVOIRS_DEF,
    parameter int IDX_W = (NUM_RESERVOIRS > 1) ? $clog2(NUM_RESERVOIRS) : 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output rec_t             rd_rec,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  rec_t             wr_rec
);

    rec_t                    rec_mem [NUM_RESERVOIRS];
    rec_t                    rd_data_reg;
    logic                    rd_vld_reg;
    logic [NUM_RESERVOIRS-1:0] vld_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            rec_mem[wr_addr] <= wr_rec;
        end
        if (rd_en) begin
            rd_data_reg <= rec_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_rec = rd_vld_reg ? rd_data_reg : '0;

endmodule

// File: hw/rtl/multi_reservoir_weighted_sampler.sv
// multi_reservoir_weighted_sampler: top level, sequencer around the shared unit
// depends on mrws_pkg, mrws_unit, mrws_store
//
//   channel | ports                    | carries
//   --------+--------------------------+---------------------------------------
//   input   | s_valid s_ready s_item   | candidate sample, weight, random draw
//   result  | m_valid m_ready m_item   | chosen slot, replaced, new sum, total
//
// an item is taken only in idle; it then passes through these steps:
// one store read per reservoir for the minimum search, one to drain the last
// read, then saturating add, multiply and the replacement decision
// a new item is not taken before the last one has left the decision step
// the single read port of the reservoir store paces the minimum search
// reset is synchronous, active low; all reservoirs read as zero afterwards
// a result not yet taken holds the decision step until the output register frees
module multi_reservoir_weighted_sampler
    import mrws_pkg::*;
#(
    parameter int NUM_RESERVOIRS = NUM_RESERVOIRS_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    localparam int IDX_W = (NUM_RESERVOIRS > 1) ? $clog2(NUM_RESERVOIRS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_RESERVOIRS - 1);

    // sequencer codes
    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_SCAN     = 3'd1;
    localparam logic [2:0] ST_SCAN_END = 3'd2;
    localparam logic [2:0] ST_ADD      = 3'd3;
    localparam logic [2:0] ST_MUL      = 3'd4;
    localparam logic [2:0] ST_DECIDE   = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [IDX_W-1:0] issue_idx_reg, issue_idx_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic             cmp_ok_reg, cmp_ok_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    rec_t             best_rec_reg, best_rec_next;
    in_item_t         item_reg, item_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic             m_valid_reg, m_valid_next;
    out_item_t        m_item_reg, m_item_next;

    // store and shared unit hookup
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    rec_t             rd_rec;
    logic             wr_en;
    rec_t             wr_rec;
    unit_req_t        unit_req;
    logic [PROD_W-1:0] unit_res;

    logic             out_free;
    logic             take;

    mrws_store #(
        .NUM_RESERVOIRS (NUM_RESERVOIRS),
        .IDX_W          (IDX_W)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_rec  (rd_rec),
        .wr_en   (wr_en),
        .wr_addr (best_idx_reg),
        .wr_rec  (wr_rec)
    );

    mrws_unit u_unit (
        .req (unit_req),
        .res (unit_res)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_item   = m_item_reg;
    assign take     = unit_res[0];

    // operand select for the shared unit, from registered values only
    always_comb begin
        // default unit use: minimum search compare of the arriving entry
        unit_req.op = OP_LESS;
        unit_req.a  = PROD_W'(rd_rec.sum);
        unit_req.b  = PROD_W'(best_rec_reg.sum);
        case (state_reg)
            ST_ADD: begin
                unit_req.op = OP_ADDSAT;
                unit_req.a  = PROD_W'(best_rec_reg.sum);
                unit_req.b  = PROD_W'(item_reg.cand_weight);
            end
            ST_MUL: begin
                // draw * new sum, registered before the compare
                unit_req.op = OP_MUL;
                unit_req.a  = PROD_W'(item_reg.uniform_draw);
                unit_req.b  = PROD_W'(sum_reg);
            end
            ST_DECIDE: begin
                // replace when draw * sum < weight * 2^16
                unit_req.op = OP_LESS;
                unit_req.a  = prod_reg;
                unit_req.b  = {item_reg.cand_weight, {(PROD_W - WEIGHT_W){1'b0}}};
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        issue_idx_next = issue_idx_reg;
        cmp_idx_next   = cmp_idx_reg;
        cmp_ok_next    = cmp_ok_reg;
        best_idx_next  = best_idx_reg;
        best_rec_next  = best_rec_reg;
        item_next      = item_reg;
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        prod_next      = prod_reg;
        total_next     = total_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_item_next    = m_item_reg;
        rd_en          = 1'b0;
        rd_addr        = issue_idx_reg;
        wr_en          = 1'b0;
        wr_rec         = best_rec_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    item_next      = s_item;
                    issue_idx_next = '0;
                    cmp_ok_next    = 1'b0;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // issue one read per cycle, compare the previous one
                rd_en        = 1'b1;
                cmp_idx_next = issue_idx_reg;
                cmp_ok_next  = 1'b1;
                if (cmp_ok_reg && ((cmp_idx_reg == '0) || take)) begin
                    best_rec_next = rd_rec;
                    best_idx_next = cmp_idx_reg;
                end
                if (issue_idx_reg == LAST_IDX) begin
                    state_next = ST_SCAN_END;
                end else begin
                    issue_idx_next = issue_idx_reg + IDX_W'(1);
                end
            end
            ST_SCAN_END: begin
                // last read arrives; strict less keeps the lowest index on ties
                if ((cmp_idx_reg == '0) || take) begin
                    best_rec_next = rd_rec;
                    best_idx_next = cmp_idx_reg;
                end
                cmp_ok_next = 1'b0;
                state_next  = ST_ADD;
            end
            ST_ADD: begin
                sum_next    = unit_res[SUM_W-1:0];
                cnt_next    = (best_rec_reg.cnt == {CNT_W{1'b1}}) ? best_rec_reg.cnt
                                                                 : best_rec_reg.cnt + CNT_W'(1);
                state_next  = ST_MUL;
            end
            ST_MUL: begin
                prod_next   = unit_res;
                state_next  = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (out_free) begin
                    wr_en      = 1'b1;
                    wr_rec.sum = sum_reg;
                    wr_rec.cnt = cnt_reg;
                    if (take) begin
                        wr_rec.pos_x   = item_reg.pos_x;
                        wr_rec.pos_y   = item_reg.pos_y;
                        wr_rec.pos_z   = item_reg.pos_z;
                        wr_rec.color_r = item_reg.color_r;
                        wr_rec.color_g = item_reg.color_g;
                        wr_rec.color_b = item_reg.color_b;
                    end
                    // running total moves only when the count did not saturate
                    total_next = total_reg + TOTAL_W'(cnt_reg != best_rec_reg.cnt);
                    m_item_next.chosen_slot = SLOT_W'(best_idx_reg);
                    m_item_next.replaced    = take;
                    m_item_next.slot_sum    = sum_reg;
                    m_item_next.total_count = total_next;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cmp_ok_reg  <= 1'b0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cmp_ok_reg  <= cmp_ok_next;
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload and working registers
    always_ff @(posedge aclk) begin
        issue_idx_reg <= issue_idx_next;
        cmp_idx_reg   <= cmp_idx_next;
        best_idx_reg  <= best_idx_next;
        best_rec_reg  <= best_rec_next;
        item_reg      <= item_next;
        sum_reg       <= sum_next;
        cnt_reg       <= cnt_next;
        prod_reg      <= prod_next;
        m_item_reg    <= m_item_next;
    end

    // chosen slot always names an existing reservoir
    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ({1'b0, m_item.chosen_slot} < 7'(NUM_RESERVOIRS)))
        else $error("chosen slot out of range");

    // a zero sum can never lead to a replacement
    a_no_take_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item.replaced) |-> (m_item.slot_sum != '0))
        else $error("replacement with zero sum");

    // an accepted item keeps the input closed on the next cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input open right after accept");

    // running count total never decreases
    a_total_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (total_reg >= $past(total_reg)))
        else $error("total count decreased");

endmodule
